// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge, reset included
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

// check a property outside reset
`define ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/psc_pkg.sv -----
// Shared types and constants of the peer status cache.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package psc_pkg;

  localparam int ACTION_W = 2;
  localparam int NODE_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int TIME_W   = 48;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;

  typedef enum logic [ACTION_W-1:0] {
    A_REMEMBER = 2'd0,
    A_LOOKUP   = 2'd1,
    A_READ     = 2'd2,
    A_CLEAR    = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_FILL,
    ST_LOOKUP,
    ST_SLOT_READ,
    ST_SLOT_DATA,
    ST_EMIT,
    ST_DRAIN,
    ST_MISS,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [TIME_W-1:0] heard;
    logic [LEN_W-1:0]  len;
  } meta_t;

endpackage

`default_nettype wire

// ----- rtl/psc_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module psc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/peer_status_cache_unit.sv -----
// Peer status cache: slot table in a metadata RAM, status text in a text RAM.
// The first text byte of a status waits for a slot scan, later bytes skip it;
// a lookup scans the slots before its first word, a slot read does not;
// then one word follows per cycle. Clear empties the table.
// The scan reads one slot per cycle through the metadata RAM port.
// Reset: synchronous; per-slot valid bits empty the table at once.
`default_nettype none

module peer_status_cache_unit #(
  parameter int CACHE_SLOTS  = 16,
  parameter int STATUS_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [psc_pkg::ACTION_W-1:0]  action,
  input  logic [psc_pkg::NODE_W-1:0]    node,
  input  logic [psc_pkg::INDEX_W-1:0]   slot_index,
  input  logic [psc_pkg::TIME_W-1:0]    now_ms,
  input  logic [psc_pkg::BYTE_W-1:0]    text_byte,
  input  logic                          text_last,
  output logic                          strobe,
  output logic                          found,
  output logic [psc_pkg::NODE_W-1:0]    peer_node,
  output logic [psc_pkg::TIME_W-1:0]    age_ms,
  output logic [psc_pkg::BYTE_W-1:0]    out_byte,
  output logic                          out_last
);

  import psc_pkg::*;

  localparam int IDX_W   = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int POS_W   = $clog2(STATUS_BYTES);
  localparam int CNT_W   = $clog2(CACHE_SLOTS + 1);
  localparam int TEXT_AW = IDX_W + POS_W;
  localparam int TEXT_DEPTH = 1 << TEXT_AW;
  localparam int META_W  = $bits(meta_t);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(STATUS_BYTES - 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(CACHE_SLOTS);

  state_t state, state_next;

  // captured item
  action_t           act;
  logic [NODE_W-1:0] key_node;
  logic [IDX_W-1:0]  key_idx;
  logic [TIME_W-1:0] key_now;
  logic [BYTE_W-1:0] key_byte;
  logic              key_last;

  // table control
  logic [CACHE_SLOTS-1:0] valid;
  logic                   filling;
  logic [IDX_W-1:0]       fill_slot;
  logic [POS_W-1:0]       fill_pos;
  logic [NODE_W-1:0]      fill_node;
  logic [TIME_W-1:0]      fill_heard;

  // scan
  logic [CNT_W-1:0]  cnt;
  logic              scan_v;
  logic [IDX_W-1:0]  rd_idx;
  logic              hit, emp;
  logic [IDX_W-1:0]  hit_idx, emp_idx, old_idx, chosen;
  logic [POS_W-1:0]  hit_len;
  logic [TIME_W-1:0] old_heard;

  // emission
  logic [IDX_W-1:0]  em_slot;
  logic [NODE_W-1:0] em_node;
  logic [TIME_W-1:0] em_age;
  logic [POS_W-1:0]  em_lastk;
  logic [POS_W-1:0]  k;
  logic              pend, pend_last, pend_next, pend_last_next;

  // direct result
  logic              direct_load, direct_found;
  logic [NODE_W-1:0] direct_node;
  logic [TIME_W-1:0] direct_age;

  // memories
  logic               meta_we, meta_re;
  logic [IDX_W-1:0]   meta_waddr, meta_raddr;
  meta_t              meta_wdata, meta_q;
  logic [META_W-1:0]  meta_rdata;
  logic               text_we, text_re;
  logic [TEXT_AW-1:0] text_waddr, text_raddr;
  logic [BYTE_W-1:0]  text_wdata, text_rdata;

  // write side of a text byte
  logic [IDX_W-1:0]  wr_slot;
  logic [POS_W-1:0]  wr_pos, wr_pos_next;
  logic [NODE_W-1:0] wr_node;
  logic [TIME_W-1:0] wr_heard;

  logic              accept, rvld;
  logic [NODE_W-1:0] e_node;
  logic [TIME_W-1:0] e_heard;
  logic [POS_W-1:0]  e_len;

  psc_ram #(.WIDTH(META_W), .DEPTH(CACHE_SLOTS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  psc_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_DEPTH)) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (text_waddr),
    .wdata (text_wdata),
    .re    (text_re),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign meta_q  = meta_rdata;
  assign rvld    = valid[rd_idx];
  assign e_node  = rvld ? meta_q.node : '0;
  assign e_heard = rvld ? meta_q.heard : '0;
  assign e_len   = rvld ? meta_q.len[POS_W-1:0] : '0;

  assign chosen   = hit ? hit_idx : (emp ? emp_idx : old_idx);
  assign wr_slot  = (state == ST_PLACE) ? chosen : fill_slot;
  assign wr_pos   = (state == ST_PLACE) ? '0 : fill_pos;
  assign wr_node  = (state == ST_PLACE) ? key_node : fill_node;
  assign wr_heard = (state == ST_PLACE) ? key_now : fill_heard;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (action_t'(action))
            A_REMEMBER: state_next = filling ? ST_FILL : ST_SCAN;
            A_LOOKUP:   state_next = (node == '0) ? ST_MISS : ST_SCAN;
            A_READ: begin
              state_next = ({1'b0, slot_index} < (INDEX_W + 1)'(CACHE_SLOTS)) ?
                           ST_SLOT_READ : ST_MISS;
            end
            A_CLEAR:    state_next = ST_CLEAR;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt == SCAN_END) begin
          state_next = (act == A_REMEMBER) ? ST_PLACE : ST_LOOKUP;
        end
      end
      ST_LOOKUP:    state_next = (hit && hit_len != '0) ? ST_EMIT : ST_IDLE;
      ST_SLOT_READ: state_next = ST_SLOT_DATA;
      ST_SLOT_DATA: state_next = (e_node != '0 && e_len != '0) ? ST_EMIT : ST_IDLE;
      ST_EMIT:      state_next = (k == em_lastk) ? ST_DRAIN : ST_EMIT;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    meta_re        = 1'b0;
    meta_raddr     = '0;
    meta_we        = 1'b0;
    meta_waddr     = wr_slot;
    meta_wdata     = '{node: wr_node, heard: wr_heard, len: '0};
    text_we        = 1'b0;
    text_waddr     = {wr_slot, wr_pos};
    text_wdata     = key_byte;
    text_re        = 1'b0;
    text_raddr     = {em_slot, k};
    wr_pos_next    = wr_pos;
    pend_next      = 1'b0;
    pend_last_next = 1'b0;
    direct_load    = 1'b0;
    direct_found   = 1'b0;
    direct_node    = '0;
    direct_age     = '0;
    case (state)
      ST_SCAN: begin
        if (cnt < SCAN_END) begin
          meta_re    = 1'b1;
          meta_raddr = cnt[IDX_W-1:0];
        end
      end
      ST_PLACE, ST_FILL: begin
        meta_we = (state == ST_PLACE);
        if (wr_pos < LAST_POS) begin
          if (key_byte == '0) begin
            wr_pos_next = LAST_POS;
          end else begin
            text_we         = 1'b1;
            meta_we         = 1'b1;
            wr_pos_next     = wr_pos + POS_W'(1);
            meta_wdata.len  = LEN_W'(wr_pos_next);
          end
        end
      end
      ST_LOOKUP: begin
        if (!hit || hit_len == '0) begin
          direct_load  = 1'b1;
          direct_found = hit;
          direct_node  = hit ? key_node : '0;
        end
      end
      ST_SLOT_READ: begin
        meta_re    = 1'b1;
        meta_raddr = key_idx;
      end
      ST_SLOT_DATA: begin
        if (e_node == '0 || e_len == '0) begin
          direct_load  = 1'b1;
          direct_found = (e_node != '0);
          direct_node  = e_node;
          direct_age   = (e_node != '0) ? key_now - e_heard : '0;
        end
      end
      ST_EMIT: begin
        text_re        = 1'b1;
        pend_next      = 1'b1;
        pend_last_next = (k == em_lastk);
      end
      ST_MISS: begin
        direct_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      filling   <= 1'b0;
      fill_slot <= '0;
      fill_pos  <= '0;
      pend      <= 1'b0;
      strobe    <= 1'b0;
      scan_v    <= 1'b0;
    end else begin
      state  <= state_next;
      pend   <= pend_next;
      strobe <= pend | direct_load;
      scan_v <= (state == ST_SCAN) && meta_re;
      if (meta_we) begin
        valid[meta_waddr] <= 1'b1;
      end
      if (state == ST_PLACE || state == ST_FILL) begin
        fill_slot <= wr_slot;
        fill_pos  <= wr_pos_next;
        filling   <= !key_last;
      end
      if (state == ST_CLEAR) begin
        valid     <= '0;
        filling   <= 1'b0;
        fill_slot <= '0;
        fill_pos  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_last <= pend_last_next;
    if (meta_re) begin
      rd_idx <= meta_raddr;
    end
    if (accept) begin
      act      <= action_t'(action);
      key_node <= node;
      key_idx  <= slot_index[IDX_W-1:0];
      key_now  <= now_ms;
      key_byte <= text_byte;
      key_last <= text_last;
      cnt      <= '0;
      hit      <= 1'b0;
      emp      <= 1'b0;
    end
    if (state == ST_SCAN) begin
      if (cnt < SCAN_END) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (scan_v) begin
        if (!hit && e_node == key_node) begin
          hit     <= 1'b1;
          hit_idx <= rd_idx;
          hit_len <= e_len;
        end
        if (!emp && e_node == '0) begin
          emp     <= 1'b1;
          emp_idx <= rd_idx;
        end
        if (rd_idx == '0 || e_heard < old_heard) begin
          old_idx   <= rd_idx;
          old_heard <= e_heard;
        end
      end
    end
    if (state == ST_PLACE) begin
      fill_node  <= key_node;
      fill_heard <= key_now;
    end
    if (state == ST_LOOKUP) begin
      em_slot  <= hit_idx;
      em_node  <= key_node;
      em_age   <= '0;
      em_lastk <= hit_len - POS_W'(1);
      k        <= '0;
    end
    if (state == ST_SLOT_DATA) begin
      em_slot  <= key_idx;
      em_node  <= e_node;
      em_age   <= key_now - e_heard;
      em_lastk <= e_len - POS_W'(1);
      k        <= '0;
    end
    if (state == ST_EMIT) begin
      k <= k + POS_W'(1);
    end
    if (pend) begin
      found     <= 1'b1;
      peer_node <= em_node;
      age_ms    <= em_age;
      out_byte  <= text_rdata;
      out_last  <= pend_last;
    end else if (direct_load) begin
      found     <= direct_found;
      peer_node <= direct_node;
      age_ms    <= direct_age;
      out_byte  <= '0;
      out_last  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/psc_checker.sv -----
// Port-level checks of the peer status cache, bound to its top level.
// Depends on psc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module psc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [psc_pkg::ACTION_W-1:0] action,
  input wire logic                         strobe,
  input wire logic                         found,
  input wire logic [psc_pkg::NODE_W-1:0]   peer_node,
  input wire logic [psc_pkg::TIME_W-1:0]   age_ms,
  input wire logic [psc_pkg::BYTE_W-1:0]   out_byte,
  input wire logic                         out_last
);

  import psc_pkg::*;

  `ASSERT_CLK(a_reset_quiet, clk, rst |=> (!busy && !strobe))
  `ASSERT_RUN(a_word_from_work, clk, rst, strobe |-> $past(busy))
  `ASSERT_RUN(a_silent_actions, clk, rst, (start && !busy && (action == A_REMEMBER || action == A_CLEAR)) |=> !strobe)
  `ASSERT_RUN(a_gap_after_last, clk, rst, (strobe && out_last) |=> !strobe)
  `ASSERT_RUN(a_miss_shape, clk, rst, (strobe && !found) |-> (out_last && peer_node == '0 && age_ms == '0 && out_byte == '0))

endmodule

bind peer_status_cache_unit psc_checker u_psc_checker (.*);

`default_nettype wire
